>>> rtl/core/nta_pkg.sv
// nta_pkg: shared types and constants for the address translation table
// with aging. Used by nta_cell and nat_table_with_aging_unit; no dependencies.
`default_nettype none

package nta_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = 5;
  localparam int KEY_W = 16;
  localparam int IP_W = 32;
  localparam int AGE_W = 8;
  localparam int REG_W = 8;
  localparam int REG_IDX_W = 1;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_INVALIDATE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_REMOVE = 1'd1;

  localparam logic [REG_W-1:0] INVALIDATE_RESET = 8'd30;
  localparam logic [REG_W-1:0] REMOVE_RESET = 8'd30;

  // item token that walks the chain of cells
  typedef struct packed {
    logic             act;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [IP_W-1:0]  iip;
    logic [IP_W-1:0]  eip;
    logic             hit;
    logic             vld;
    logic [IP_W-1:0]  fi;
    logic [IP_W-1:0]  fe;
    logic             free_seen;
    logic [IDX_W-1:0] free_idx;
    logic [CNT_W-1:0] removed;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/core/nta_cell.sv
// nta_cell: one table slot with its key, addresses, age and marks, plus the
// token register that hands the item to the next slot. Depends on nta_pkg.
`default_nettype none

module nta_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nta_pkg::tok_t               tok_in,
  output nta_pkg::tok_t                    tok_out,
  input  wire logic [nta_pkg::IDX_W-1:0]   slot,
  input  wire logic                        wr,
  input  wire logic [nta_pkg::KEY_W-1:0]   wr_key,
  input  wire logic [nta_pkg::IP_W-1:0]    wr_int,
  input  wire logic [nta_pkg::IP_W-1:0]    wr_ext,
  input  wire logic [nta_pkg::REG_W-1:0]   inv_after,
  input  wire logic [nta_pkg::REG_W-1:0]   rem_after
);

  logic                        occ;
  logic                        occ_next;
  logic                        vmark;
  logic                        vmark_next;
  logic [nta_pkg::KEY_W-1:0]   key;
  logic [nta_pkg::IP_W-1:0]    iip;
  logic [nta_pkg::IP_W-1:0]    eip;
  logic [nta_pkg::AGE_W-1:0]   age;
  logic [nta_pkg::AGE_W-1:0]   age_next;
  logic [nta_pkg::AGE_W-1:0]   age_inc;
  nta_pkg::tok_t               tok_next;

  assign age_inc = (age == {nta_pkg::AGE_W{1'b1}}) ? age : age + 1'b1;

  always_comb begin
    tok_next = tok_in;
    occ_next = occ;
    vmark_next = vmark;
    age_next = age;
    if (tok_in.act) begin
      unique case (tok_in.cmd)
        nta_pkg::CMD_INSERT, nta_pkg::CMD_LOOKUP: begin
          if (occ && key == tok_in.key && !tok_in.hit) begin
            tok_next.hit = 1'b1;
            tok_next.fi = iip;
            tok_next.fe = eip;
            tok_next.vld = (tok_in.cmd == nta_pkg::CMD_LOOKUP) && vmark;
          end
          if (!occ && !tok_in.free_seen) begin
            tok_next.free_seen = 1'b1;
            tok_next.free_idx = slot;
          end
        end
        nta_pkg::CMD_TICK: begin
          if (occ) begin
            age_next = age_inc;
            if (vmark && age_inc > inv_after) begin
              vmark_next = 1'b0;
            end
            if (age_inc >= rem_after) begin
              occ_next = 1'b0;
              vmark_next = 1'b0;
              if (tok_in.removed != {nta_pkg::CNT_W{1'b1}}) begin
                tok_next.removed = tok_in.removed + 1'b1;
              end
            end
          end
        end
        nta_pkg::CMD_CLEAR: begin
          occ_next = 1'b0;
          vmark_next = 1'b0;
        end
      endcase
    end
    if (wr) begin
      occ_next = 1'b1;
      vmark_next = 1'b1;
      age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      vmark <= 1'b0;
      tok_out.act <= 1'b0;
    end else begin
      occ <= occ_next;
      vmark <= vmark_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    age <= age_next;
    if (wr) begin
      key <= wr_key;
      iip <= wr_int;
      eip <= wr_ext;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nat_table_with_aging_unit.sv
// nat_table_with_aging_unit: top level, a chain of nta_cell slots, the
// sequencer, result hold stage and output register. Depends on nta_pkg, nta_cell.
`default_nettype none

// An item enters the first slot of a chain of TABLE_ENTRIES cells and moves one
// slot per cycle; each slot compares, ages or clears its own entry as the item
// passes and adds what it found to the item. After the last slot the result is
// captured in the result hold register (an insert writes its new entry into the
// chosen slot in the same cycle) and moves into the output register once that is
// free. The next item is taken as soon as the result sits in the output
// register, even if it is not yet taken. Register writes take effect at once.
module nat_table_with_aging_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        command,
  input  wire logic [nta_pkg::KEY_W-1:0]         query_id,
  input  wire logic [nta_pkg::IP_W-1:0]          priv_addr,
  input  wire logic [nta_pkg::IP_W-1:0]          pub_addr,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   hit,
  output logic                                   entry_valid,
  output logic [nta_pkg::IP_W-1:0]               found_priv_addr,
  output logic [nta_pkg::IP_W-1:0]               found_pub_addr,
  output logic [1:0]                             status,
  output logic [nta_pkg::CNT_W-1:0]              removed_count,
  input  wire logic                              cfg_write,
  input  wire logic [nta_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [nta_pkg::REG_W-1:0]         cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic [nta_pkg::REG_W-1:0]           inv_after;
  logic [nta_pkg::REG_W-1:0]           rem_after;
  logic                                accept;
  logic                                out_load;
  logic                                do_write;
  nta_pkg::tok_t                       chain [nta_pkg::TABLE_ENTRIES+1];
  nta_pkg::tok_t                       tail;
  logic [nta_pkg::TABLE_ENTRIES-1:0]   act_vec;
  logic [nta_pkg::TABLE_ENTRIES-1:0]   we_vec;

  logic                                res_hit;
  logic                                res_vld;
  logic [nta_pkg::IP_W-1:0]            res_fi;
  logic [nta_pkg::IP_W-1:0]            res_fe;
  logic [1:0]                          res_status;
  logic [nta_pkg::CNT_W-1:0]           res_removed;
  logic [1:0]                          tail_status;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_load = (state == S_HOLD) && (!out_valid || !out_stall);
  assign tail = chain[nta_pkg::TABLE_ENTRIES];

  always_comb begin
    chain[0].act = accept;
    chain[0].cmd = command;
    chain[0].key = query_id;
    chain[0].iip = priv_addr;
    chain[0].eip = pub_addr;
    chain[0].hit = 1'b0;
    chain[0].vld = 1'b0;
    chain[0].fi = '0;
    chain[0].fe = '0;
    chain[0].free_seen = 1'b0;
    chain[0].free_idx = '0;
    chain[0].removed = '0;
  end

  assign do_write = tail.act && tail.cmd == nta_pkg::CMD_INSERT && !tail.hit
                    && tail.free_seen;

  for (genvar i = 0; i < nta_pkg::TABLE_ENTRIES; i++) begin : g_cell
    assign we_vec[i] = do_write && tail.free_idx == nta_pkg::IDX_W'(i);
    assign act_vec[i] = chain[i+1].act;

    nta_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1]),
      .slot      (nta_pkg::IDX_W'(i)),
      .wr        (we_vec[i]),
      .wr_key    (tail.key),
      .wr_int    (tail.iip),
      .wr_ext    (tail.eip),
      .inv_after (inv_after),
      .rem_after (rem_after)
    );
  end

  always_comb begin
    priority if (tail.cmd == nta_pkg::CMD_INSERT && tail.hit) begin
      tail_status = nta_pkg::ST_PRESENT;
    end else if (tail.cmd == nta_pkg::CMD_INSERT && !tail.free_seen) begin
      tail_status = nta_pkg::ST_FULL;
    end else begin
      tail_status = nta_pkg::ST_DONE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_RUN;
      S_RUN: if (tail.act) state_next = S_HOLD;
      S_HOLD: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      inv_after <= nta_pkg::INVALIDATE_RESET;
      rem_after <= nta_pkg::REMOVE_RESET;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          nta_pkg::REG_INVALIDATE: inv_after <= cfg_data;
          nta_pkg::REG_REMOVE: rem_after <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.act) begin
      res_hit <= tail.hit;
      res_vld <= tail.vld;
      res_fi <= tail.fi;
      res_fe <= tail.fe;
      res_status <= tail_status;
      res_removed <= tail.removed;
    end
    if (out_load) begin
      hit <= res_hit;
      entry_valid <= res_vld;
      found_priv_addr <= res_fi;
      found_pub_addr <= res_fe;
      status <= res_status;
      removed_count <= res_removed;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(act_vec))
    else $error("more than one item in the cell chain");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(we_vec))
    else $error("more than one slot written");

  a_tail_in_run: assert property (@(posedge clk) disable iff (rst)
    tail.act |-> state == S_RUN)
    else $error("item left the chain outside the run state");

  a_chain_empty_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_RUN |-> act_vec == '0)
    else $error("item in the chain while not running");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RUN || state == S_HOLD)
    else $error("accepted item not in progress");

endmodule

`default_nettype wire

>>> dv/nat_table_with_aging_unit_tb.sv
// nat_table_with_aging_unit_tb: self-checking testbench for the aging address
// translation table, with a built-in table predictor and random traffic.
// Depends on nta_pkg and the nat_table_with_aging_unit RTL only.
`default_nettype none

module nat_table_with_aging_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic                      hit;
    logic                      vld;
    logic [nta_pkg::IP_W-1:0]  fi;
    logic [nta_pkg::IP_W-1:0]  fe;
    logic [1:0]                status;
    logic [nta_pkg::CNT_W-1:0] removed;
  } xlate_res_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    command;
  logic [nta_pkg::KEY_W-1:0]     query_id;
  logic [nta_pkg::IP_W-1:0]      priv_addr;
  logic [nta_pkg::IP_W-1:0]      pub_addr;
  logic                          out_valid;
  logic                          out_stall;
  logic                          hit;
  logic                          entry_valid;
  logic [nta_pkg::IP_W-1:0]      found_priv_addr;
  logic [nta_pkg::IP_W-1:0]      found_pub_addr;
  logic [1:0]                    status;
  logic [nta_pkg::CNT_W-1:0]     removed_count;
  logic                          cfg_write;
  logic [nta_pkg::REG_IDX_W-1:0] cfg_index;
  logic [nta_pkg::REG_W-1:0]     cfg_data;

  // predicted table contents and timeouts
  logic                      tbl_used [nta_pkg::TABLE_ENTRIES];
  logic                      tbl_live [nta_pkg::TABLE_ENTRIES];
  logic [nta_pkg::KEY_W-1:0] tbl_key  [nta_pkg::TABLE_ENTRIES];
  logic [nta_pkg::IP_W-1:0]  tbl_int  [nta_pkg::TABLE_ENTRIES];
  logic [nta_pkg::IP_W-1:0]  tbl_ext  [nta_pkg::TABLE_ENTRIES];
  logic [nta_pkg::AGE_W-1:0] tbl_age  [nta_pkg::TABLE_ENTRIES];
  logic [nta_pkg::REG_W-1:0] inval_limit;
  logic [nta_pkg::REG_W-1:0] remove_limit;

  xlate_res_t answers_due[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_full = 0;
  int  n_present = 0;
  int  n_aged = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  quiet = 1'b0;

  nat_table_with_aging_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .query_id        (query_id),
    .priv_addr       (priv_addr),
    .pub_addr        (pub_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .entry_valid     (entry_valid),
    .found_priv_addr (found_priv_addr),
    .found_pub_addr  (found_pub_addr),
    .status          (status),
    .removed_count   (removed_count),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int find_key(input logic [nta_pkg::KEY_W-1:0] key);
    int slot;
    slot = -1;
    for (int i = 0; i < nta_pkg::TABLE_ENTRIES; i++)
      if (slot < 0 && tbl_used[i] && tbl_key[i] == key) slot = i;
    return slot;
  endfunction

  function automatic xlate_res_t translate_step(input logic [1:0] cmd,
                                                input logic [nta_pkg::KEY_W-1:0] key,
                                                input logic [nta_pkg::IP_W-1:0] iip,
                                                input logic [nta_pkg::IP_W-1:0] eip);
    xlate_res_t res;
    int slot;
    res = '0;
    slot = -1;
    case (cmd)
      nta_pkg::CMD_INSERT: begin
        slot = find_key(key);
        if (slot >= 0) begin
          res.hit = 1'b1;
          res.status = nta_pkg::ST_PRESENT;
          res.fi = tbl_int[slot];
          res.fe = tbl_ext[slot];
        end else begin
          for (int i = 0; i < nta_pkg::TABLE_ENTRIES; i++)
            if (slot < 0 && !tbl_used[i]) slot = i;
          if (slot < 0) begin
            res.status = nta_pkg::ST_FULL;
          end else begin
            tbl_used[slot] = 1'b1;
            tbl_live[slot] = 1'b1;
            tbl_key[slot] = key;
            tbl_int[slot] = iip;
            tbl_ext[slot] = eip;
            tbl_age[slot] = '0;
          end
        end
      end
      nta_pkg::CMD_LOOKUP: begin
        slot = find_key(key);
        if (slot >= 0) begin
          res.hit = 1'b1;
          res.vld = tbl_live[slot];
          res.fi = tbl_int[slot];
          res.fe = tbl_ext[slot];
        end
      end
      nta_pkg::CMD_TICK: begin
        for (int i = 0; i < nta_pkg::TABLE_ENTRIES; i++) begin
          if (tbl_used[i]) begin
            if (tbl_age[i] != '1) tbl_age[i] = tbl_age[i] + 1'b1;
            if (tbl_live[i] && tbl_age[i] > inval_limit) tbl_live[i] = 1'b0;
            if (tbl_age[i] >= remove_limit) begin
              tbl_used[i] = 1'b0;
              tbl_live[i] = 1'b0;
              if (res.removed != '1) res.removed = res.removed + 1'b1;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < nta_pkg::TABLE_ENTRIES; i++) begin
          tbl_used[i] = 1'b0;
          tbl_live[i] = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    xlate_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit));
        check_field("entry_valid", 32'(want.vld), 32'(entry_valid));
        check_field("found_priv_addr", want.fi, found_priv_addr);
        check_field("found_pub_addr", want.fe, found_pub_addr);
        check_field("status", 32'(want.status), 32'(status));
        check_field("removed_count", 32'(want.removed), 32'(removed_count));
        n_checked++;
        if (want.status == nta_pkg::ST_FULL) n_full++;
        if (want.status == nta_pkg::ST_PRESENT) n_present++;
        n_aged += int'(want.removed);
      end
    end
  end

  // result side back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (quiet || $urandom_range(0, 99) >= stall_pct) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [nta_pkg::KEY_W-1:0] key,
                           input logic [nta_pkg::IP_W-1:0] iip,
                           input logic [nta_pkg::IP_W-1:0] eip);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    query_id <= key;
    priv_addr <= iip;
    pub_addr <= eip;
    do @(posedge clk); while (in_stall);
    answers_due.insert(answers_due.size(), translate_step(cmd, key, iip, eip));
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [nta_pkg::REG_IDX_W-1:0] idx,
                           input logic [nta_pkg::REG_W-1:0] data);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == nta_pkg::REG_INVALIDATE) inval_limit = data;
    else remove_limit = data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_timeouts(input logic [nta_pkg::REG_W-1:0] inval,
                              input logic [nta_pkg::REG_W-1:0] rem);
    write_reg(nta_pkg::REG_INVALIDATE, inval);
    write_reg(nta_pkg::REG_REMOVE, rem);
  endtask

  task automatic test_insert_lookup();
    send_item(nta_pkg::CMD_LOOKUP, 16'h0000, '0, '0);
    send_item(nta_pkg::CMD_INSERT, 16'h0000, '0, '0);
    send_item(nta_pkg::CMD_INSERT, 16'hffff, '1, '1);
    send_item(nta_pkg::CMD_LOOKUP, 16'h0000, '1, '1);
    send_item(nta_pkg::CMD_LOOKUP, 16'hffff, '0, '0);
    send_item(nta_pkg::CMD_INSERT, 16'hffff, 32'h0a00_0001, 32'hc0a8_0101);
    send_item(nta_pkg::CMD_LOOKUP, 16'h1234, '0, '0);
    send_item(nta_pkg::CMD_TICK, '1, '1, '1);
  endtask

  task automatic test_aging_and_removal();
    set_timeouts(8'd1, 8'd3);
    send_item(nta_pkg::CMD_INSERT, 16'h00a5, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    send_item(nta_pkg::CMD_TICK, '0, '0, '0);
    send_item(nta_pkg::CMD_LOOKUP, 16'h00a5, '0, '0);
    send_item(nta_pkg::CMD_TICK, '0, '0, '0);
    send_item(nta_pkg::CMD_LOOKUP, 16'h00a5, '0, '0);
    send_item(nta_pkg::CMD_INSERT, 16'h00a5, 32'h1111_1111, 32'h2222_2222);
    send_item(nta_pkg::CMD_TICK, '0, '0, '0);
    send_item(nta_pkg::CMD_LOOKUP, 16'h00a5, '0, '0);
  endtask

  task automatic test_clear();
    send_item(nta_pkg::CMD_INSERT, 16'h8001, 32'h8000_0001, 32'h7fff_fffe);
    send_item(nta_pkg::CMD_INSERT, 16'h7ffe, 32'h0102_0304, 32'hfffe_fdfc);
    send_item(nta_pkg::CMD_CLEAR, 16'h8001, '0, '0);
    send_item(nta_pkg::CMD_LOOKUP, 16'h8001, '0, '0);
    send_item(nta_pkg::CMD_INSERT, 16'h7ffe, 32'hdead_beef, 32'hcafe_f00d);
  endtask

  // insert, lookup, tick and clear traffic on a small key pool so hits, duplicates
  // and a full table come up often
  task automatic test_random_traffic(input int n, input int tick_pct, input int clear_pct);
    logic [nta_pkg::KEY_W-1:0] pool [POOL_SIZE];
    logic [1:0] cmd;
    logic [nta_pkg::KEY_W-1:0] key;
    int r;
    foreach (pool[i]) pool[i] = nta_pkg::KEY_W'($urandom);
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct) cmd = nta_pkg::CMD_CLEAR;
      else if (r < clear_pct + tick_pct) cmd = nta_pkg::CMD_TICK;
      else if (r < clear_pct + tick_pct + (100 - clear_pct - tick_pct) / 2)
        cmd = nta_pkg::CMD_INSERT;
      else cmd = nta_pkg::CMD_LOOKUP;
      if ($urandom_range(0, 9) == 0) key = nta_pkg::KEY_W'($urandom);
      else key = pool[$urandom_range(0, POOL_SIZE - 1)];
      send_item(cmd, key, $urandom, $urandom);
    end
  endtask

  task automatic test_longest_timeout();
    set_timeouts(8'd254, 8'd255);
    send_item(nta_pkg::CMD_CLEAR, '0, '0, '0);
    send_item(nta_pkg::CMD_INSERT, 16'h4242, 32'hffff_0000, 32'h0000_ffff);
    send_item(nta_pkg::CMD_INSERT, 16'h2424, 32'h00ff_00ff, 32'hff00_ff00);
    repeat (253) send_item(nta_pkg::CMD_TICK, nta_pkg::KEY_W'($urandom), $urandom, $urandom);
    send_item(nta_pkg::CMD_LOOKUP, 16'h4242, '0, '0);
    send_item(nta_pkg::CMD_TICK, '0, '0, '0);
    send_item(nta_pkg::CMD_LOOKUP, 16'h2424, '0, '0);
    send_item(nta_pkg::CMD_TICK, '0, '0, '0);
    send_item(nta_pkg::CMD_LOOKUP, 16'h4242, '0, '0);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = nta_pkg::CMD_LOOKUP;
    query_id = '0;
    priv_addr = '0;
    pub_addr = '0;
    cfg_write = 1'b0;
    cfg_index = nta_pkg::REG_INVALIDATE;
    cfg_data = '0;
    inval_limit = nta_pkg::INVALIDATE_RESET;
    remove_limit = nta_pkg::REMOVE_RESET;
    for (int i = 0; i < nta_pkg::TABLE_ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_live[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_int[i] = '0;
      tbl_ext[i] = '0;
      tbl_age[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    stall_pct = 20;
    test_insert_lookup();
    test_aging_and_removal();
    test_clear();

    set_timeouts(nta_pkg::INVALIDATE_RESET, nta_pkg::REMOVE_RESET);
    idle_pct = 30;
    stall_pct = 30;
    test_random_traffic(180, 20, 2);

    set_timeouts(8'd1, 8'd1);
    idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(150, 10, 1);

    set_timeouts(8'd255, 8'd255);
    idle_pct = 50;
    stall_pct = 40;
    test_random_traffic(180, 20, 3);

    set_timeouts(8'd1, 8'd255);
    idle_pct = 15;
    stall_pct = 60;
    test_random_traffic(180, 25, 2);

    set_timeouts(8'd255, 8'd1);
    idle_pct = 40;
    stall_pct = 10;
    test_random_traffic(120, 15, 1);

    set_timeouts(8'($urandom_range(1, 12)), 8'($urandom_range(1, 16)));
    idle_pct = 25;
    stall_pct = 25;
    test_random_traffic(150, 25, 2);

    idle_pct = 10;
    stall_pct = 10;
    test_longest_timeout();

    set_timeouts(8'($urandom_range(2, 8)), 8'($urandom_range(4, 12)));
    quiet = 1'b1;
    test_random_traffic(150, 20, 2);

    drain();
    repeat (nta_pkg::TABLE_ENTRIES + 8) @(posedge clk);
    $display("sent %0d items, checked %0d results: %0d table full, %0d duplicate inserts,",
             n_sent, n_checked, n_full, n_present);
    $display("%0d entries aged out across several timeout settings", n_aged);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
